>>> sv/frechet_free_space_reachability_core_assert.svh
// ----------------------------------------------------------------------------
// Reachability core assertion macros
// Shorthand for the concurrent checks used by the core checker.
// ----------------------------------------------------------------------------
`ifndef FRECHET_FREE_SPACE_REACHABILITY_CORE_ASSERT_SVH
`define FRECHET_FREE_SPACE_REACHABILITY_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define FFSR_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ffsr check failed");

// Next-cycle implication, off while reset is high.
`define FFSR_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ffsr check failed");

// Next-cycle implication that also runs through reset.
`define FFSR_ASSERT_NXT_ALL(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("ffsr check failed");

`endif

>>> sv/ffsr_pkg.sv
// ----------------------------------------------------------------------------
// ffsr_pkg
// Shared types, constants and interval helpers of the reachability core.
// ----------------------------------------------------------------------------
package ffsr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int VAL_W      = FRAC_BITS + 1;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int POS_W      = $clog2(MAX_WIDTH);
  localparam int ADDR_W     = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_W       = 8 * VAL_W;
  localparam int OUT_BITS   = 8 * VAL_W + 4;
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [VAL_W-1:0] ONE_FX  = VAL_W'(1) << FRAC_BITS;
  localparam logic [VAL_W-1:0] ZERO_FX = '0;

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

  localparam logic [1:0] PRED_NONE   = 2'd0;
  localparam logic [1:0] PRED_LEFT   = 2'd1;
  localparam logic [1:0] PRED_BOTTOM = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] s;
    logic [VAL_W-1:0] e;
  } span_t;

  typedef struct packed {
    span_t bottom;
    span_t left;
    span_t top;
    span_t right;
  } cell_t;

  typedef struct packed {
    span_t bottom_carry;
    span_t first_row;
    span_t first_col;
  } carry_t;

  typedef struct packed {
    span_t      bottom;
    span_t      left;
    span_t      top;
    span_t      right;
    logic [1:0] pred;
  } reach_t;

  typedef struct packed {
    logic [POS_W-1:0]  i;
    logic [ADDR_W-1:0] j;
    logic              last;
  } pos_t;

  function automatic span_t span_empty();
    span_t r;
    r.s = ONE_FX;
    r.e = ZERO_FX;
    return r;
  endfunction

  function automatic logic span_is_empty(span_t a);
    return a.s > a.e;
  endfunction

  function automatic logic span_has(span_t a, logic [VAL_W-1:0] x);
    return (a.s <= x) && (x <= a.e);
  endfunction

  function automatic span_t span_norm(span_t a);
    return span_is_empty(a) ? span_empty() : a;
  endfunction

endpackage

>>> sv/ffsr_pos_ctrl.sv
// ----------------------------------------------------------------------------
// ffsr_pos_ctrl
// Grid size registers and the column/row position of the next cell.
// ----------------------------------------------------------------------------
module ffsr_pos_ctrl
  import ffsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 step,
  output pos_t                 pos
);

  logic [DIM_W-1:0]  grid_width;
  logic [DIM_W-1:0]  grid_height;
  logic [POS_W-1:0]  outer;
  logic [ADDR_W-1:0] inner;

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic              out_of_grid;
  logic [POS_W-1:0]  ic;
  logic [ADDR_W-1:0] jc;
  logic              col_end;
  logic              row_end;
  logic [POS_W-1:0]  outer_next;
  logic [ADDR_W-1:0] inner_next;

  always_comb begin
    // zero acts as one, oversize acts as the maximum
    w_eff = (grid_width == '0) ? DIM_W'(1) :
            (grid_width > MAX_W_DIM) ? MAX_W_DIM : grid_width;
    h_eff = (grid_height == '0) ? DIM_W'(1) :
            (grid_height > MAX_H_DIM) ? MAX_H_DIM : grid_height;
    out_of_grid = (DIM_W'(outer) >= w_eff) || (DIM_W'(inner) >= h_eff);
    ic = out_of_grid ? '0 : outer;
    jc = out_of_grid ? '0 : inner;
    col_end = (DIM_W'(jc) + DIM_W'(1)) >= h_eff;
    row_end = (DIM_W'(ic) + DIM_W'(1)) >= w_eff;
    if (col_end) begin
      inner_next = '0;
      outer_next = row_end ? '0 : ic + POS_W'(1);
    end else begin
      inner_next = jc + ADDR_W'(1);
      outer_next = ic;
    end
    pos.i    = ic;
    pos.j    = jc;
    pos.last = (DIM_W'(ic) == w_eff - DIM_W'(1)) && (DIM_W'(jc) == h_eff - DIM_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(1);
      grid_height <= DIM_W'(1);
      outer       <= '0;
      inner       <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_wdata;
        REG_GRID_HEIGHT: grid_height <= cfg_wdata;
        default: ;
      endcase
      outer <= '0;
      inner <= '0;
    end else if (step) begin
      outer <= outer_next;
      inner <= inner_next;
    end
  end

endmodule

>>> sv/ffsr_line_store.sv
// ----------------------------------------------------------------------------
// ffsr_line_store
// Right results of the previous column, one entry per row, registered read.
// ----------------------------------------------------------------------------
module ffsr_line_store
  import ffsr_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  span_t             wr_data,
  output span_t             rd_data
);

  span_t mem [MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // forward a same-edge write so a one-row grid sees its own right result
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    end
  end

endmodule

>>> sv/ffsr_cell_calc.sv
// ----------------------------------------------------------------------------
// ffsr_cell_calc
// Reachable edge intervals of one cell and the updated carries.
// ----------------------------------------------------------------------------
module ffsr_cell_calc
  import ffsr_pkg::*;
(
  input  cell_t  edges,
  input  logic   i_zero,
  input  logic   j_zero,
  input  span_t  left_prev,
  input  carry_t carry,
  output reach_t reach,
  output carry_t carry_next
);

  logic  bottom_ok;
  logic  left_ok;
  span_t rb;
  span_t rl;
  span_t rt;
  span_t rr;
  span_t mix;

  always_comb begin
    bottom_ok = span_has(edges.bottom, ZERO_FX) &&
                (i_zero || span_has(carry.first_row, ONE_FX));
    left_ok   = span_has(edges.left, ZERO_FX) &&
                (j_zero || span_has(carry.first_col, ONE_FX));

    rb = j_zero ? (bottom_ok ? span_norm(edges.bottom) : span_empty()) : carry.bottom_carry;
    rl = i_zero ? (left_ok ? span_norm(edges.left) : span_empty()) : left_prev;

    mix = span_empty();
    if (!span_is_empty(rl)) begin
      rt = span_norm(edges.top);
      reach.pred = PRED_LEFT;
    end else if (!span_is_empty(rb)) begin
      mix.s = (rb.s > edges.top.s) ? rb.s : edges.top.s;
      mix.e = edges.top.e;
      rt = span_norm(mix);
      reach.pred = PRED_BOTTOM;
    end else begin
      rt = span_empty();
      reach.pred = PRED_NONE;
    end

    if (!span_is_empty(rb)) begin
      rr = span_norm(edges.right);
    end else if (!span_is_empty(rl)) begin
      rr.s = (rl.s > edges.right.s) ? rl.s : edges.right.s;
      rr.e = edges.right.e;
      rr = span_norm(rr);
    end else begin
      rr = span_empty();
    end

    reach.bottom = rb;
    reach.left   = rl;
    reach.top    = rt;
    reach.right  = rr;

    carry_next.bottom_carry = rt;
    carry_next.first_row    = j_zero ? rb : carry.first_row;
    carry_next.first_col    = i_zero ? rl : carry.first_col;
  end

endmodule

>>> sv/frechet_free_space_reachability_core.sv
// ----------------------------------------------------------------------------
// frechet_free_space_reachability_core
// Alt-Godau reachability over a free-space grid streamed column by column.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: free edge intervals
//  m_*     | out | m_tvalid/m_tready  | m_tdata: reach intervals + preds,
//          |     |                    | m_tlast: last cell of the grid
//  cfg_*   | in  | cfg_wen            | cfg_index, cfg_wdata: grid size
//
//  One cell per cycle while m_tready stays high; a result passes the input
//  register, then the result register. The line store read starts at the
//  input transfer, so its data meets the cell in the input register.
//  Synchronous reset clears the valid flags, carries and positions; the line
//  store has no reset and is always written before its read data is used.
//  A stall on m_* holds the result; once both registers are full, s_tready drops.
// ----------------------------------------------------------------------------
module frechet_free_space_reachability_core
  import ffsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // grid_width (index 0), grid_height (index 1)
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // from bit 0: free_bottom_start, free_bottom_end, free_left_start,
  // free_left_end, free_top_start, free_top_end, free_right_start,
  // free_right_end (17 bits each)
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // from bit 0: reach_bottom_start, reach_bottom_end, reach_left_start,
  // reach_left_end, reach_top_start, reach_top_end, reach_right_start,
  // reach_right_end (17 bits each), pred_top (2), pred_right (2), zero pad
  output logic [OUT_W-1:0]     m_tdata,
  // last_cell
  output logic                 m_tlast
);

  // handshake
  logic   in_valid;
  logic   out_valid;
  logic   advance;
  logic   fire;
  logic   accept;

  // input register
  cell_t             in_cell;
  logic              in_i_zero;
  logic              in_j_zero;
  logic [ADDR_W-1:0] in_j;
  logic              in_last;

  // result register
  reach_t out_reach;
  logic   out_last;

  pos_t   pos;
  span_t  left_prev;
  carry_t carry;
  carry_t carry_next;
  reach_t reach;
  cell_t  s_cell;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // unpack the input transfer
  assign s_cell.bottom.s = s_tdata[0*VAL_W +: VAL_W];
  assign s_cell.bottom.e = s_tdata[1*VAL_W +: VAL_W];
  assign s_cell.left.s   = s_tdata[2*VAL_W +: VAL_W];
  assign s_cell.left.e   = s_tdata[3*VAL_W +: VAL_W];
  assign s_cell.top.s    = s_tdata[4*VAL_W +: VAL_W];
  assign s_cell.top.e    = s_tdata[5*VAL_W +: VAL_W];
  assign s_cell.right.s  = s_tdata[6*VAL_W +: VAL_W];
  assign s_cell.right.e  = s_tdata[7*VAL_W +: VAL_W];

  // advance the grid position on each input transfer unless a config write restarts it
  ffsr_pos_ctrl u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (accept),
    .pos       (pos)
  );

  // read the row entry as the cell enters, write the right result as it leaves
  ffsr_line_store u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (pos.j),
    .wr_en   (fire),
    .wr_addr (in_j),
    .wr_data (reach.right),
    .rd_data (left_prev)
  );

  ffsr_cell_calc u_calc (
    .edges      (in_cell),
    .i_zero     (in_i_zero),
    .j_zero     (in_j_zero),
    .left_prev  (left_prev),
    .carry      (carry),
    .reach      (reach),
    .carry_next (carry_next)
  );

  // control: valid flags and carries
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      carry.bottom_carry <= span_empty();
      carry.first_row    <= span_empty();
      carry.first_col    <= span_empty();
    end else begin
      if (accept) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
        carry     <= carry_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: hold the cell with its position, load the result on fire
  always_ff @(posedge clk) begin
    if (accept) begin
      in_cell   <= s_cell;
      in_i_zero <= (pos.i == '0);
      in_j_zero <= (pos.j == '0);
      in_j      <= pos.j;
      in_last   <= pos.last;
    end
    if (fire) begin
      out_reach <= reach;
      out_last  <= in_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = OUT_W'({out_reach.pred, out_reach.pred,
                            out_reach.right.e, out_reach.right.s,
                            out_reach.top.e, out_reach.top.s,
                            out_reach.left.e, out_reach.left.s,
                            out_reach.bottom.e, out_reach.bottom.s});

endmodule

>>> sv/ffsr_checker.sv
// ----------------------------------------------------------------------------
// ffsr_checker
// Port-level checks of the reachability core, bound to the top level.
// ----------------------------------------------------------------------------
`include "frechet_free_space_reachability_core_assert.svh"

module ffsr_checker
  import ffsr_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OUT_W-1:0]     m_tdata,
  input logic                 m_tlast
);

  logic [VAL_W-1:0] bot_s;
  logic [VAL_W-1:0] bot_e;

  assign bot_s = m_tdata[0 +: VAL_W];
  assign bot_e = m_tdata[VAL_W +: VAL_W];

  // a stalled result holds
  `FFSR_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // reset leaves no result pending
  `FFSR_ASSERT_NXT_ALL(a_reset_clear, clk, rst, !m_tvalid)

  // a ready sink never throttles the input
  `FFSR_ASSERT_IMP(a_no_backpressure, clk, rst, m_tready, s_tready)

  // an empty bottom interval is normalized and both predecessor codes agree and are legal
  `FFSR_ASSERT_IMP(a_result_form, clk, rst, m_tvalid,
    (!(bot_s > bot_e) || (bot_s == ONE_FX && bot_e == ZERO_FX)) &&
    (m_tdata[8*VAL_W +: 2] == m_tdata[8*VAL_W+2 +: 2]) &&
    (m_tdata[8*VAL_W +: 2] != 2'd3))

endmodule

bind frechet_free_space_reachability_core ffsr_checker u_ffsr_checker (.*);

>>> verif/frechet_free_space_reachability_core_checker.sv
// ----------------------------------------------------------------------------
// Reachability core checker
// Watches the config port and both streams, predicts each cell's reachable
// intervals and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module frechet_free_space_reachability_core_checker
  import ffsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [OUT_W-1:0]     m_tdata,
  input  logic                 m_tlast,
  output int unsigned          error_count,
  output int unsigned          open_count,
  output int unsigned          result_count
);

  typedef struct packed {
    span_t      bottom;
    span_t      left;
    span_t      top;
    span_t      right;
    logic [1:0] pred_top;
    logic [1:0] pred_right;
    logic       last;
  } cell_reach_t;

  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  span_t            left_mem [MAX_HEIGHT];
  span_t            top_carry;
  span_t            row_chain;
  span_t            col_chain;
  int unsigned      col_i;
  int unsigned      row_j;
  cell_reach_t      reach_q [$];

  initial begin
    error_count  = 0;
    open_count   = 0;
    result_count = 0;
  end

  function automatic span_t void_span();
    span_t r;
    r.s = ONE_FX;
    r.e = '0;
    return r;
  endfunction

  function automatic logic is_void(span_t a);
    return a.s > a.e;
  endfunction

  function automatic logic covers(span_t a, logic [VAL_W-1:0] x);
    return (a.s <= x) && (x <= a.e);
  endfunction

  function automatic span_t tidy(span_t a);
    return is_void(a) ? void_span() : a;
  endfunction

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  // Span k of a packed stream word: start at the lower slot, end above it.
  function automatic span_t lane(logic [OUT_W-1:0] d, int k);
    span_t r;
    r.s = d[2*k*VAL_W +: VAL_W];
    r.e = d[(2*k+1)*VAL_W +: VAL_W];
    return r;
  endfunction

  // Propagate one cell through the grid state and return what it yields.
  function automatic cell_reach_t predict_cell(logic [OUT_W-1:0] d);
    int unsigned w;
    int unsigned h;
    int unsigned i;
    int unsigned j;
    span_t       fb;
    span_t       fl;
    span_t       ft;
    span_t       fr;
    cell_reach_t r;
    logic        ok;
    w  = clamp_dim(width_q, MAX_WIDTH);
    h  = clamp_dim(height_q, MAX_HEIGHT);
    i  = col_i;
    j  = row_j;
    fb = lane(d, 0);
    fl = lane(d, 1);
    ft = lane(d, 2);
    fr = lane(d, 3);
    if (i >= w || j >= h) begin
      i = 0;
      j = 0;
    end
    if (j == 0) begin
      ok = covers(fb, '0) && (i == 0 || covers(row_chain, ONE_FX));
      r.bottom  = ok ? tidy(fb) : void_span();
      row_chain = r.bottom;
    end else begin
      r.bottom = top_carry;
    end
    if (i == 0) begin
      ok = covers(fl, '0) && (j == 0 || covers(col_chain, ONE_FX));
      r.left    = ok ? tidy(fl) : void_span();
      col_chain = r.left;
    end else begin
      r.left = left_mem[j];
    end
    if (!is_void(r.left)) begin
      r.top      = tidy(ft);
      r.pred_top = PRED_LEFT;
    end else if (!is_void(r.bottom)) begin
      r.top.s    = (r.bottom.s > ft.s) ? r.bottom.s : ft.s;
      r.top.e    = ft.e;
      r.top      = tidy(r.top);
      r.pred_top = PRED_BOTTOM;
    end else begin
      r.top      = void_span();
      r.pred_top = PRED_NONE;
    end
    if (!is_void(r.bottom)) begin
      r.right = tidy(fr);
    end else if (!is_void(r.left)) begin
      r.right.s = (r.left.s > fr.s) ? r.left.s : fr.s;
      r.right.e = fr.e;
      r.right   = tidy(r.right);
    end else begin
      r.right = void_span();
    end
    r.pred_right = r.pred_top;
    top_carry    = r.top;
    left_mem[j]  = r.right;
    r.last       = (i == w - 1) && (j == h - 1);
    if (j + 1 >= h) begin
      row_j = 0;
      col_i = (i + 1 >= w) ? 0 : i + 1;
    end else begin
      row_j = j + 1;
      col_i = i;
    end
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    cell_reach_t want;
    cell_reach_t got;
    if (rst) begin
      width_q   = DIM_W'(1);
      height_q  = DIM_W'(1);
      top_carry = void_span();
      row_chain = void_span();
      col_chain = void_span();
      col_i     = 0;
      row_j     = 0;
      reach_q.delete();
    end else begin
      if (cfg_wen) begin
        if (cfg_index == REG_GRID_WIDTH) width_q = cfg_wdata;
        else                             height_q = cfg_wdata;
        col_i = 0;
        row_j = 0;
      end
      // Check the outgoing transfer first: it can never belong to a cell
      // accepted at this same edge.
      if (m_tvalid && m_tready) begin
        result_count++;
        got.bottom     = lane(m_tdata, 0);
        got.left       = lane(m_tdata, 1);
        got.top        = lane(m_tdata, 2);
        got.right      = lane(m_tdata, 3);
        got.pred_top   = m_tdata[8*VAL_W +: 2];
        got.pred_right = m_tdata[8*VAL_W+2 +: 2];
        got.last       = m_tlast;
        if (reach_q.size() == 0) begin
          $error("result transfer with no cell waiting");
          error_count++;
        end else begin
          want = reach_q.pop_front();
          compare_field("reach_bottom_start", want.bottom.s, got.bottom.s);
          compare_field("reach_bottom_end", want.bottom.e, got.bottom.e);
          compare_field("reach_left_start", want.left.s, got.left.s);
          compare_field("reach_left_end", want.left.e, got.left.e);
          compare_field("reach_top_start", want.top.s, got.top.s);
          compare_field("reach_top_end", want.top.e, got.top.e);
          compare_field("reach_right_start", want.right.s, got.right.s);
          compare_field("reach_right_end", want.right.e, got.right.e);
          compare_field("pred_top", want.pred_top, got.pred_top);
          compare_field("pred_right", want.pred_right, got.pred_right);
          compare_field("last_cell", want.last, got.last);
        end
      end
      if (s_tvalid && s_tready) reach_q.push_back(predict_cell(OUT_W'(s_tdata)));
    end
    open_count = reach_q.size();
  end

endmodule

>>> verif/frechet_free_space_reachability_core_tb.sv
// ----------------------------------------------------------------------------
// Reachability core testbench
// Streams free-space cells through the core over a series of grid sizes,
// with bursty input, a patterned output stall and one long back-pressure
// stretch; the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module frechet_free_space_reachability_core_tb;
  import ffsr_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned STALL_LIMIT     = 4000;
  // Length of the single long output hold-off.
  localparam int unsigned PRESSURE_CYCLES = 400;
  localparam logic [VAL_W-1:0] TOP_FX     = '1;
  localparam logic [VAL_W-1:0] HALF_FX    = ONE_FX >> 1;
  localparam logic [VAL_W-1:0] QUART_FX   = ONE_FX >> 2;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 m_tlast;

  int unsigned error_count;
  int unsigned open_count;
  int unsigned result_count;
  int unsigned cells_sent    = 0;
  int unsigned grids_used    = 0;
  int unsigned burst_left    = 0;
  bit          pressure_req  = 1'b0;
  bit          pressure_done = 1'b0;

  always #1 clk = ~clk;

  frechet_free_space_reachability_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  frechet_free_space_reachability_core_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .error_count  (error_count),
    .open_count   (open_count),
    .result_count (result_count)
  );

  // Pack one cell: free_bottom_start lands in bit 0, free_right_end on top.
  function automatic logic [IN_W-1:0] pack_cell(
    logic [VAL_W-1:0] bs, logic [VAL_W-1:0] be,
    logic [VAL_W-1:0] ls, logic [VAL_W-1:0] le,
    logic [VAL_W-1:0] ts, logic [VAL_W-1:0] te,
    logic [VAL_W-1:0] rs, logic [VAL_W-1:0] re);
    return {re, rs, te, ts, le, ls, be, bs};
  endfunction

  // Edge value: mostly inside [0, 1.0], with the endpoints and values
  // above 1.0 showing up often.
  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ONE_FX;
      2:       return VAL_W'($urandom_range(ONE_FX + 1, TOP_FX));
      default: return VAL_W'($urandom_range(0, ONE_FX));
    endcase
  endfunction

  // One free interval as {end, start}. Full spans dominate so that the
  // first-row and first-column chains survive long enough to reach the
  // interior; raw bit patterns and inverted spans supply the noise.
  function automatic logic [2*VAL_W-1:0] rand_span();
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    a = rand_value();
    b = rand_value();
    case ($urandom_range(0, 11))
      0, 1, 2, 3: return (a <= b) ? {b, a} : {a, b};
      4, 5, 6:    return {ONE_FX, VAL_W'(0)};
      7:          return {b, VAL_W'(0)};
      8:          return {ONE_FX, a};
      9:          return (a > b) ? {b, a} : {a, b};
      default:    return {VAL_W'($urandom), VAL_W'($urandom)};
    endcase
  endfunction

  function automatic logic [IN_W-1:0] rand_cell();
    return {rand_span(), rand_span(), rand_span(), rand_span()};
  endfunction

  // Offer one cell and hold it until the core takes it. Bursts of random
  // length are separated by short gaps with tvalid low.
  task automatic send_cell(input logic [IN_W-1:0] d);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 16);
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cells_sent++;
  endtask

  // Drain the core, then write both size registers; each write restarts
  // the grid at cell (0,0).
  task automatic set_grid(input int unsigned w, input int unsigned h);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (open_count != 0);
    repeat (3) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_wdata <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_wdata <= CFG_W'(h);
    @(posedge clk);
    cfg_wen   <= 1'b0;
    grids_used++;
  endtask

  // Output side: tready follows a random mode that is redrawn when its run
  // of random length ends, except for the one long hold-off when it is requested.
  initial begin : receiver_pattern
    int unsigned mode;
    int unsigned mode_left;
    mode_left = 0;
    mode      = 0;
    forever begin
      @(posedge clk);
      if (pressure_req && !pressure_done) begin
        m_tready <= 1'b0;
        repeat (PRESSURE_CYCLES - 1) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 9) < 7);
          2:       m_tready <= ~m_tready;
          default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // Hang detector: count cycles in which neither stream moves a transfer.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else                                                         quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned grid_w [7];
    int unsigned grid_h [7];
    int unsigned grid_n [7];
    grid_w = '{5, 2047, 1, 2, 7, 1024, 1};
    grid_h = '{4, 1, 1, 1024, 3, 2, 6};
    grid_n = '{120, 300, 40, 1100, 150, 150, 90};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes (1 x 1): every cell is corner (0,0) and the last cell.
    send_cell(pack_cell(0, 0, 0, 0, 0, 0, 0, 0));
    send_cell(pack_cell(ONE_FX, ONE_FX, ONE_FX, ONE_FX, ONE_FX, ONE_FX, ONE_FX,
                        ONE_FX));
    send_cell(pack_cell(0, ONE_FX, 0, ONE_FX, 0, ONE_FX, 0, ONE_FX));
    // Values above 1.0 pass through as plain numbers.
    send_cell(pack_cell(0, TOP_FX, 0, TOP_FX, TOP_FX, TOP_FX, ONE_FX + VAL_W'(5),
                        TOP_FX));
    // Both entries empty: nothing reachable, no predecessor.
    send_cell(pack_cell(5, 4, ONE_FX, 0, 0, ONE_FX, 0, ONE_FX));
    // Bottom reachable, left empty.
    send_cell(pack_cell(0, HALF_FX, 9, 3, QUART_FX, ONE_FX, QUART_FX >> 1, HALF_FX));

    // Size zero behaves as one.
    set_grid(0, 0);
    send_cell(pack_cell(0, ONE_FX, 0, ONE_FX, HALF_FX, ONE_FX, 0, QUART_FX));
    send_cell(pack_cell(0, 0, 1, 0, 0, ONE_FX, 0, ONE_FX));

    // 3 x 2 grid, run past its end so that the positions wrap.
    set_grid(3, 2);
    send_cell(pack_cell(0, ONE_FX, 0, ONE_FX, HALF_FX, ONE_FX, QUART_FX, ONE_FX));
    send_cell(pack_cell(0, 0, 3, 2, QUART_FX, ONE_FX - QUART_FX, 0, ONE_FX));
    send_cell(pack_cell(0, ONE_FX, 0, ONE_FX, 0, ONE_FX, HALF_FX, ONE_FX));
    send_cell(pack_cell(0, ONE_FX, 0, ONE_FX, ONE_FX, HALF_FX, QUART_FX, HALF_FX));
    send_cell(pack_cell(HALF_FX, ONE_FX, 0, ONE_FX, 0, ONE_FX, ONE_FX, ONE_FX));
    send_cell(pack_cell(0, ONE_FX, 7, 6, 0, TOP_FX, 0, ONE_FX));
    send_cell(pack_cell(0, ONE_FX, 0, ONE_FX, 0, ONE_FX, 0, ONE_FX));
    send_cell(pack_cell(0, HALF_FX, 0, HALF_FX, 0, ONE_FX, 0, ONE_FX));

    // Height above the maximum behaves as the maximum.
    set_grid(1, 2047);
    send_cell(pack_cell(0, ONE_FX, 0, ONE_FX, 0, ONE_FX, 0, ONE_FX));
    send_cell(pack_cell(0, ONE_FX, 0, ONE_FX, HALF_FX, ONE_FX, 0, ONE_FX));
    send_cell(pack_cell(0, ONE_FX, 0, HALF_FX, 0, ONE_FX, 0, ONE_FX));

    // Random cells over a list of grid sizes; phase counts that are not
    // whole grids leave a grid half done before the next size write.
    foreach (grid_w[p]) begin
      set_grid(grid_w[p], grid_h[p]);
      for (int unsigned k = 0; k < grid_n[p]; k++) begin
        if (p == 0 && k == 30) pressure_req = 1'b1;
        send_cell(rand_cell());
      end
    end

    // Drop tvalid and let every outstanding result drain.
    s_tvalid <= 1'b0;
    do @(negedge clk); while (open_count != 0);
    repeat (10) @(posedge clk);

    $display("Covered %0d cells over %0d size settings plus reset sizes, %0d results checked",
             cells_sent, grids_used, result_count);
    if (error_count == 0) $display("RESULT: OK");
    else                  $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> frechet_free_space_reachability_core.f
+incdir+sv
sv/ffsr_pkg.sv
sv/ffsr_pos_ctrl.sv
sv/ffsr_line_store.sv
sv/ffsr_cell_calc.sv
sv/frechet_free_space_reachability_core.sv
sv/ffsr_checker.sv
verif/frechet_free_space_reachability_core_checker.sv
verif/frechet_free_space_reachability_core_tb.sv
